FILE: src/hcc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hcc_pkg
// Shared types, constants and round functions for the HChaCha20 subkey
// derivation pipeline.
// ============================================================================
package hcc_pkg;

    // Request: one 128-bit nonce, little-endian words 12..15
    typedef struct packed {
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
    } t_hcc_in;

    // Response: final state words 0..3 and 12..15
    typedef struct packed {
        logic [63:0] subkey_part3;
        logic [63:0] subkey_part2;
        logic [63:0] subkey_part1;
        logic [63:0] subkey_part0;
    } t_hcc_out;

    // Sixteen 32-bit state words, word 0 in the low bits
    typedef logic [15:0][31:0] t_hcc_state;

    // Which half of which quarter round a pipeline stage applies
    typedef struct packed {
        logic diag;    // 0: column round, 1: diagonal round
        logic second;  // 0: rotates 16/12, 1: rotates 8/7
    } t_hcc_step;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_KEY_PART0 = 2'd0,
        REG_KEY_PART1 = 2'd1,
        REG_KEY_PART2 = 2'd2,
        REG_KEY_PART3 = 2'd3
    } t_hcc_reg;

    localparam int HCC_NUM_KEY_REGS = 4;

    // 10 double rounds, 2 rounds each, 2 half quarter rounds per round
    localparam int HCC_STAGES = 40;

    // "expand 32-byte k"
    localparam logic [31:0] HCC_SIGMA [4] = '{
        32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
    };

    // Half of all four quarter rounds of a column or diagonal round:
    //   a += b; d ^= a; d <<<= 16|8; c += d; b ^= c; b <<<= 12|7
    function automatic t_hcc_state hcc_half_round(t_hcc_state s, t_hcc_step step);
        t_hcc_state  r;
        logic [3:0]  ia;
        logic [3:0]  ib;
        logic [3:0]  ic;
        logic [3:0]  id;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        r = s;
        for (int i = 0; i < 4; i++) begin
            // diagonal lanes shift by one word per row
            ia = {2'd0, 2'(i)};
            ib = {2'd1, 2'(i + (step.diag ? 1 : 0))};
            ic = {2'd2, 2'(i + (step.diag ? 2 : 0))};
            id = {2'd3, 2'(i + (step.diag ? 3 : 0))};
            a = s[ia] + s[ib];
            d = s[id] ^ a;
            d = step.second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
            c = s[ic] + d;
            b = s[ib] ^ c;
            b = step.second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
            r[ia] = a;
            r[ib] = b;
            r[ic] = c;
            r[id] = d;
        end
        return r;
    endfunction

endpackage

FILE: src/hcc_round_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// hcc_round_stage
// One pipeline stage: applies one half quarter round to all four lanes of
// the state and registers the result with its valid bit.
// ============================================================================
module hcc_round_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  hcc_pkg::t_hcc_step i_step,
    input  logic               i_valid,
    input  hcc_pkg::t_hcc_state i_state,
    output logic               o_valid,
    output hcc_pkg::t_hcc_state o_state
);
    import hcc_pkg::*;

    logic       r_valid;
    t_hcc_state r_state;
    t_hcc_state n_state;

    // round logic
    always_comb begin
        n_state = hcc_half_round(i_state, i_step);
    end

    // valid bit: cleared by reset, advances with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

FILE: src/hcc_out_skid.sv
`timescale 1ns / 1ps
// ============================================================================
// hcc_out_skid
// Output register plus one skid entry. The pipeline holds only while the
// skid entry is full, so the hold signal comes straight from a flop.
// ============================================================================
module hcc_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hcc_pkg::t_hcc_out i_data,
    output logic              o_full,
    output logic              o_valid,
    output hcc_pkg::t_hcc_out o_data,
    input  logic              i_stall
);
    import hcc_pkg::*;

    logic     r_out_valid;
    logic     r_skid_valid;
    t_hcc_out r_out;
    t_hcc_out r_skid;
    logic     n_out_valid;
    logic     n_skid_valid;
    logic     w_take;
    logic     w_push;
    logic     w_load_skid;
    logic     w_load_in;
    logic     w_fill_skid;

    assign w_take = r_out_valid && !i_stall;
    assign w_push = i_valid && !r_skid_valid;

    // output slot free: refill from skid first, else from the pipeline
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        w_load_skid  = 1'b0;
        w_load_in    = 1'b0;
        w_fill_skid  = 1'b0;
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                w_load_skid  = 1'b1;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (w_push) begin
                w_load_in   = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_push) begin
            w_fill_skid  = 1'b1;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_skid) begin
            r_out <= r_skid;
        end else if (w_load_in) begin
            r_out <= i_data;
        end
        if (w_fill_skid) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // skid entry is only ever used behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output register empty");

    // a result arriving at a stalled, full output must land in the skid entry
    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !r_skid_valid && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("result dropped at stalled output");

    // a taken output with a full skid entry is refilled and the skid drains
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry did not drain");

endmodule

FILE: src/hchacha20_subkey_derivation.sv
`timescale 1ns / 1ps
// ============================================================================
// hchacha20_subkey_derivation
// HChaCha20: derives a 256-bit subkey from the configured key and a nonce.
// ============================================================================
// Accepts one nonce request per cycle and returns one subkey per request, in
// order. The datapath is 40 round stages (each stage is half of the four
// parallel quarter rounds, two chained 32-bit adds, so ten double rounds take
// 40 stages) plus the output register. The output has a skid entry, so input
// is held (o_stall) only while that entry is occupied; a result waiting at a
// stalled output does not block new requests. The key registers feed the
// first stage directly and must be written only while no request is in flight.
module hchacha20_subkey_derivation (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  hcc_pkg::t_hcc_reg i_cfg_idx,
    input  logic [63:0]       i_cfg_data,
    // request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  hcc_pkg::t_hcc_in  i_req,
    // response channel
    output logic              o_valid,
    input  logic              i_stall,
    output hcc_pkg::t_hcc_out o_rsp
);
    import hcc_pkg::*;

    logic [63:0] r_key [HCC_NUM_KEY_REGS];
    logic        w_valid [HCC_STAGES + 1];
    t_hcc_state  w_state [HCC_STAGES + 1];
    t_hcc_state  w_init;
    t_hcc_out    w_result;
    logic        w_en;
    logic        w_full;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HCC_NUM_KEY_REGS; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_PART0: r_key[0] <= i_cfg_data;
                REG_KEY_PART1: r_key[1] <= i_cfg_data;
                REG_KEY_PART2: r_key[2] <= i_cfg_data;
                REG_KEY_PART3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // initial state: constants, key, nonce
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_init[i]         = HCC_SIGMA[i];
            w_init[4 + 2 * i] = r_key[i][31:0];
            w_init[5 + 2 * i] = r_key[i][63:32];
        end
        w_init[12] = i_req.nonce_low[31:0];
        w_init[13] = i_req.nonce_low[63:32];
        w_init[14] = i_req.nonce_high[31:0];
        w_init[15] = i_req.nonce_high[63:32];
    end

    // whole pipeline advances unless the output skid entry is occupied
    assign w_en       = !w_full;
    assign o_stall    = w_full;
    assign w_valid[0] = i_valid;
    assign w_state[0] = w_init;

    // round stages: column first half, column second half, diagonal ...
    for (genvar j = 0; j < HCC_STAGES; j++) begin : g_stage
        hcc_round_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_step  (t_hcc_step'{diag: 1'((j / 2) % 2), second: 1'(j % 2)}),
            .i_valid (w_valid[j]),
            .i_state (w_state[j]),
            .o_valid (w_valid[j + 1]),
            .o_state (w_state[j + 1])
        );
    end

    // subkey words 0..3 and 12..15, no feed-forward
    always_comb begin
        w_result.subkey_part0 = {w_state[HCC_STAGES][1],  w_state[HCC_STAGES][0]};
        w_result.subkey_part1 = {w_state[HCC_STAGES][3],  w_state[HCC_STAGES][2]};
        w_result.subkey_part2 = {w_state[HCC_STAGES][13], w_state[HCC_STAGES][12]};
        w_result.subkey_part3 = {w_state[HCC_STAGES][15], w_state[HCC_STAGES][14]};
    end

    hcc_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[HCC_STAGES]),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_valid),
        .o_data  (o_rsp),
        .i_stall (i_stall)
    );

    // an accepted request enters the first stage on the same edge
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_valid[1])
        else $error("accepted request missing from first stage");

    // while held, the last stage keeps its result
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_full && w_valid[HCC_STAGES]) |=>
            (w_valid[HCC_STAGES] && $stable(w_state[HCC_STAGES])))
        else $error("last stage changed while pipeline held");

    // after a result leaves the pipeline, o_valid is set next cycle
    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_valid[HCC_STAGES]) |=> o_valid)
        else $error("result lost at pipeline exit");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - HChaCha20 subkey derivation testbench
// Drives nonce requests through hchacha20_subkey_derivation under several key
// settings and idle/stall mixes. A scoreboard recomputes every subkey with a
// behavioral ChaCha double-round model and checks responses in order.
// ============================================================================

// Scoreboard: key shadow, subkey predictor, in-order queue of expected subkeys
class hcc_subkey_board;
    logic [63:0]            key_part [4];
    logic [31:0]            st [16];
    hcc_pkg::t_hcc_out      pending_subkeys [$];
    int                     errors;

    function new();
        foreach (key_part[i]) key_part[i] = '0;
        errors = 0;
    endfunction

    function void set_key(hcc_pkg::t_hcc_reg idx, logic [63:0] value);
        key_part[idx] = value;
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter_round(int a, int b, int c, int d);
        st[a] = st[a] + st[b]; st[d] = rotl(st[d] ^ st[a], 16);
        st[c] = st[c] + st[d]; st[b] = rotl(st[b] ^ st[c], 12);
        st[a] = st[a] + st[b]; st[d] = rotl(st[d] ^ st[a], 8);
        st[c] = st[c] + st[d]; st[b] = rotl(st[b] ^ st[c], 7);
    endfunction

    // Full HChaCha20: 20 rounds, no feed-forward, keep rows 0 and 3
    function hcc_pkg::t_hcc_out derive_subkey(hcc_pkg::t_hcc_in req);
        hcc_pkg::t_hcc_out rsp;
        st[0] = 32'h61707865;
        st[1] = 32'h3320646e;
        st[2] = 32'h79622d32;
        st[3] = 32'h6b206574;
        for (int i = 0; i < 4; i++) begin
            st[4 + 2 * i] = key_part[i][31:0];
            st[5 + 2 * i] = key_part[i][63:32];
        end
        st[12] = req.nonce_low[31:0];
        st[13] = req.nonce_low[63:32];
        st[14] = req.nonce_high[31:0];
        st[15] = req.nonce_high[63:32];
        for (int r = 0; r < 10; r++) begin
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
        end
        rsp.subkey_part0 = {st[1], st[0]};
        rsp.subkey_part1 = {st[3], st[2]};
        rsp.subkey_part2 = {st[13], st[12]};
        rsp.subkey_part3 = {st[15], st[14]};
        return rsp;
    endfunction

    function void note_request(hcc_pkg::t_hcc_in req);
        pending_subkeys.push_back(derive_subkey(req));
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task compare_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_response(hcc_pkg::t_hcc_out got);
        hcc_pkg::t_hcc_out want;
        if (pending_subkeys.size() == 0) begin
            report_mismatch("response with no request pending", got[63:0], '0);
            return;
        end
        want = pending_subkeys.pop_front();
        compare_field("subkey_part0", got.subkey_part0, want.subkey_part0);
        compare_field("subkey_part1", got.subkey_part1, want.subkey_part1);
        compare_field("subkey_part2", got.subkey_part2, want.subkey_part2);
        compare_field("subkey_part3", got.subkey_part3, want.subkey_part3);
    endtask
endclass

module tb;
    import hcc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 60;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    t_hcc_reg    i_cfg_idx  = REG_KEY_PART0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    t_hcc_in     i_req      = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    t_hcc_out    o_rsp;

    int              send_idle_pct = 0;
    int              stall_pct     = 0;
    int              cycles        = 0;
    hcc_subkey_board board;

    hchacha20_subkey_derivation DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Response side: check accepted responses, then pick next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_response(o_rsp);
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Random 64-bit value biased toward extremes and one-hot and one-cold patterns
    function automatic logic [63:0] rand_word64();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(63);
            3: return ~(64'h1 << $urandom_range(63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Write the key registers selected by mask on back-to-back cycles
    task automatic load_key(input logic [3:0][63:0] key, input logic [3:0] mask);
        for (int i = 0; i < HCC_NUM_KEY_REGS; i++) begin
            if (mask[i]) begin
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= t_hcc_reg'(i);
                i_cfg_data <= key[i];
                @(posedge i_clk);
                board.set_key(t_hcc_reg'(i), key[i]);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    // One nonce request, with an optional random idle gap in front
    task automatic send_nonce(input logic [63:0] lo, input logic [63:0] hi);
        t_hcc_in req;
        req.nonce_low  = lo;
        req.nonce_high = hi;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_stall);
        board.note_request(req);
    endtask

    // Stop sending and wait until every subkey has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_subkeys.size() != 0) @(posedge i_clk);
    endtask

    int              idle_mix  [4] = '{0, 77, 0, 22};
    int              stall_mix [4] = '{0, 0, 77, 22};
    logic [3:0][63:0] key;

    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset key (all zero): nonce extremes, alternating patterns and single bits
        send_nonce('0, '0);
        send_nonce('1, '1);
        send_nonce({16{4'h5}}, {16{4'hA}});
        send_nonce({16{4'hA}}, {16{4'h5}});
        send_nonce('1, '0);
        send_nonce('0, '1);
        send_nonce(64'h1, '0);
        send_nonce(64'h1 << 63, '0);
        send_nonce('0, 64'h1);
        send_nonce('0, 64'h1 << 63);
        drain();

        // All-ones key
        key = {4{64'hFFFF_FFFF_FFFF_FFFF}};
        load_key(key, 4'hF);
        send_nonce('0, '0);
        send_nonce('1, '1);
        drain();

        // Byte-counting key with the well-known test nonce
        key[0] = 64'h0706050403020100;
        key[1] = 64'h0f0e0d0c0b0a0908;
        key[2] = 64'h1716151413121110;
        key[3] = 64'h1f1e1d1c1b1a1918;
        load_key(key, 4'hF);
        send_nonce(64'h4a00000009000000, 64'h2759413100000000);
        send_nonce(rand_word64(), rand_word64());
        drain();

        // Partial rewrite: only one key part changes
        key[2] = 64'h8000_0000_0000_0001;
        load_key(key, 4'b0100);
        send_nonce(64'h4a00000009000000, 64'h2759413100000000);
        send_nonce(rand_word64(), rand_word64());
        drain();

        // Random traffic under each idle/stall mix, key changes in between
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_mix[p];
            stall_pct     = stall_mix[p];
            for (int blk = 0; blk < 4; blk++) begin
                for (int i = 0; i < 4; i++) key[i] = rand_word64();
                load_key(key, (blk == 0) ? 4'hF : 4'($urandom_range(1, 15)));
                repeat (50) send_nonce(rand_word64(), rand_word64());
                drain();
            end
        end

        // Catch any stray responses
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.pending_subkeys.size() != 0)
            board.report_mismatch("requests left without response",
                                  64'(board.pending_subkeys.size()), '0);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: files.f
src/hcc_pkg.sv
src/hcc_round_stage.sv
src/hcc_out_skid.sv
src/hchacha20_subkey_derivation.sv
dv/tb.sv
